// ===== src/kpt_pkg.sv =====
// Package for the keyed position table: request, status and position-kind codes,
// controller states, command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kpt_pkg;
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_PRUNE  = 3'd3;
  localparam logic [2:0] REQ_NEXT   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [2:0] NONE     = 3'd0;
  localparam logic [2:0] ESTIMATE = 3'd1;
  localparam logic [2:0] UNKNOWN  = 3'd2;
  localparam logic [2:0] KNOWN    = 3'd3;
  localparam logic [2:0] FIXED    = 3'd4;

  localparam int REC_W = 16 + 3 + 32 + 32 + 16 + 16;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_FILL, S_DONE, S_OUT
  } state_t;

  typedef struct packed {
    logic load;      // latch request word, reset scan
    logic scan;      // examine one slot (read data present)
    logic fill;      // allocate first free slot for add
    logic finish;    // resolve result, issue RAM read of found slot
    logic capture;   // latch output word
  } cmd_t;

  typedef struct packed {
    logic scan_end;  // last slot examined or early stop
  } sts_t;
endpackage
`default_nettype wire

// ===== src/kpt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/kpt_ctrl.sv =====
// Controller for the keyed position table: sequences the slot scan.
// Depends on kpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic        need_fill,
  input  kpt_pkg::sts_t    sts,
  output kpt_pkg::cmd_t    cmd
);
  kpt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kpt_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpt_pkg::S_IDLE: if (in_valid) state_nxt = kpt_pkg::S_WAIT;
      kpt_pkg::S_WAIT: state_nxt = kpt_pkg::S_SCAN;
      kpt_pkg::S_SCAN: if (sts.scan_end) state_nxt = need_fill ? kpt_pkg::S_FILL
                                                               : kpt_pkg::S_DONE;
      kpt_pkg::S_FILL: state_nxt = kpt_pkg::S_DONE;
      kpt_pkg::S_DONE: state_nxt = kpt_pkg::S_OUT;
      kpt_pkg::S_OUT:  if (out_ready) state_nxt = kpt_pkg::S_IDLE;
      default:         state_nxt = kpt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      kpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      kpt_pkg::S_SCAN: cmd.scan = 1'b1;
      kpt_pkg::S_FILL: cmd.fill = 1'b1;
      kpt_pkg::S_DONE: cmd.capture = 1'b1;
      kpt_pkg::S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
    cmd.finish = (state_r == kpt_pkg::S_SCAN && sts.scan_end && !need_fill) ||
                 state_r == kpt_pkg::S_FILL;
  end
endmodule
`default_nettype wire

// ===== src/kpt_dp.sv =====
// Datapath for the keyed position table: valid bits, record RAM, scan counter,
// match logic and result register. Depends on kpt_pkg and kpt_ram.
`timescale 1ns / 1ps
`default_nettype none
module kpt_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [15:0]        in_entry_id,
  input  wire logic [2:0]         in_pos_kind,
  input  wire logic signed [31:0] in_x_mm,
  input  wire logic signed [31:0] in_y_mm,
  input  wire logic [15:0]        in_epoch_value,
  input  wire logic [15:0]        in_pos_err,
  input  wire logic [3:0]         in_start_index,
  input  kpt_pkg::cmd_t           cmd,
  output kpt_pkg::sts_t           sts,
  output logic                    need_fill,
  output logic [1:0]              out_status,
  output logic                    out_hit,
  output logic [3:0]              out_slot_index,
  output logic [15:0]             out_id,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_x_mm,
  output logic signed [31:0]      out_y_mm,
  output logic [15:0]             out_epoch,
  output logic [15:0]             out_pos_err,
  output logic [4:0]              entries_used
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = kpt_pkg::REC_W;

  logic [15:0] prune_age_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]  req_r;
  logic [15:0] id_r, ep_r, err_r, min_ep_r;
  logic [2:0]  kind_r;
  logic [31:0] x_r, y_r;
  logic [4:0]  start_r;
  logic [AW:0] idx_r;          // slot address of read data in flight
  logic        found_r;
  logic [AW-1:0] f_r;
  logic        writing_r;

  logic          we;
  logic [AW-1:0] raddr, waddr;
  logic [RW-1:0] rdata, wdata;
  logic [15:0]   r_id, r_ep;
  logic [2:0]    r_kind;

  kpt_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_id   = rdata[RW-1 -: 16];
  assign r_kind = rdata[RW-17 -: 3];
  assign r_ep   = rdata[31:16];

  logic [AW-1:0] slot;
  logic          sval, match, last;
  assign slot = idx_r[AW-1:0];
  assign sval = valid_r[slot];
  assign last = (idx_r == (AW+1)'(TABLE_DEPTH - 1));

  always_comb begin
    match = 1'b0;
    case (req_r)
      kpt_pkg::REQ_ADD: match = sval && r_id == id_r && r_kind == kind_r;
      kpt_pkg::REQ_LOOKUP, kpt_pkg::REQ_REMOVE: match = sval && r_id == id_r;
      kpt_pkg::REQ_NEXT: match = sval && ({{(5 > AW ? 5 - AW : 0){1'b0}}, slot} >=
                                           start_r[4:0]);
      default: match = 1'b0;
    endcase
  end

  // first free slot (lowest index with its valid bit clear; used by the add fill)
  logic          free_ok;
  logic [AW-1:0] free_i;
  always_comb begin
    free_ok = 1'b0;
    free_i = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_i = AW'(i);
      end
  end

  assign sts.scan_end = last || (match && !found_r);
  assign need_fill = (req_r == kpt_pkg::REQ_ADD) && !found_r && !match;

  logic prune_drop;
  assign prune_drop = req_r == kpt_pkg::REQ_PRUNE && prune_age_r != 16'd0 && sval &&
                      (r_ep < min_ep_r || r_ep > ep_r);

  // hold the read address on the current slot until the scan advances
  assign raddr = cmd.finish ? (cmd.fill ? free_i :
                               ((match && !found_r) ? slot : f_r))
                            : (cmd.load ? '0 :
                               (cmd.scan ? AW'(idx_r + 1'b1) : slot));
  assign we = writing_r;
  assign waddr = f_r;
  assign wdata = {id_r, kind_r, x_r, y_r, ep_r, err_r};

  logic [1:0] st_r;
  logic       hit_r, rec_r;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd.scan && prune_drop) begin
      valid_nxt[slot] = 1'b0;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.finish && !cmd.fill && req_r == kpt_pkg::REQ_REMOVE &&
        (found_r || match)) begin
      valid_nxt[(match && !found_r) ? slot : f_r] = 1'b0;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.fill && free_ok && count_r < CW'(TABLE_DEPTH)) begin
      valid_nxt[free_i] = 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prune_age_r <= '0;
      valid_r <= '0;
      count_r <= '0;
      writing_r <= 1'b0;
    end else begin
      if (cfg_we) prune_age_r <= cfg_wdata;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      writing_r <= cmd.finish && req_r == kpt_pkg::REQ_ADD &&
                   (!cmd.fill || (free_ok && count_r < CW'(TABLE_DEPTH)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type; id_r <= in_entry_id; kind_r <= in_pos_kind;
      x_r <= in_x_mm; y_r <= in_y_mm; ep_r <= in_epoch_value;
      err_r <= in_pos_err; start_r <= {1'b0, in_start_index};
      min_ep_r <= in_epoch_value - prune_age_r;
      idx_r <= '0; found_r <= 1'b0;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      if (match && !found_r) begin
        found_r <= 1'b1;
        f_r <= slot;
      end
    end
    if (cmd.finish) begin
      // resolve status; f_r now names the slot read in the next cycle
      hit_r <= 1'b0; rec_r <= 1'b0; st_r <= kpt_pkg::ST_MISS;
      if (cmd.fill) begin
        f_r <= free_i;
        if (free_ok && count_r < CW'(TABLE_DEPTH)) begin
          st_r <= kpt_pkg::ST_OK; rec_r <= 1'b1;
        end else st_r <= kpt_pkg::ST_FULL;
      end else begin
        case (req_r)
          kpt_pkg::REQ_PRUNE: st_r <= kpt_pkg::ST_OK;
          kpt_pkg::REQ_ADD, kpt_pkg::REQ_LOOKUP, kpt_pkg::REQ_REMOVE,
          kpt_pkg::REQ_NEXT:
            if (found_r || match) begin
              st_r <= kpt_pkg::ST_OK; hit_r <= 1'b1; rec_r <= 1'b1;
            end
          default: st_r <= kpt_pkg::ST_MISS;
        endcase
      end
    end
    if (cmd.capture) begin
      out_status <= st_r;
      out_hit <= hit_r;
      entries_used <= 5'(count_r);
      if (rec_r && req_r == kpt_pkg::REQ_ADD) begin
        out_slot_index <= 4'(f_r);
        {out_id, out_kind, out_x_mm, out_y_mm, out_epoch, out_pos_err} <= wdata;
      end else if (rec_r) begin
        out_slot_index <= 4'(f_r);
        {out_id, out_kind, out_x_mm, out_y_mm, out_epoch, out_pos_err} <= rdata;
      end else begin
        out_slot_index <= '0;
        {out_id, out_kind, out_x_mm, out_y_mm, out_epoch, out_pos_err} <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/keyed_position_table_with_aging.sv =====
// Top level of the keyed position table with aging.
// Depends on kpt_pkg, kpt_ctrl, kpt_dp (and kpt_ram through kpt_dp).
//
// Usage:
//   Requests enter as one word on in_* (valid/ready); each produces exactly one
//   result word on out_* (valid/ready). cfg_we writes prune_age; the user must
//   write it only while the block is idle (the block does not enforce this);
//   zero disables pruning. Sequence: after acceptance the block waits for the
//   first RAM read, scans the table one slot per cycle, fills a new slot for an
//   add that found no match, then captures and presents the result. Lookup,
//   remove, add-update and next stop at the first match; a request with no
//   match, and every prune, scans the whole table. The scan is set by the
//   single read port of the record RAM. Throughput: one word at a time;
//   in_ready is high only while no request is in flight and returns the cycle
//   after the result is taken.
//   When the receiver stalls, hold the result word in the output register
//   and accept nothing until it is taken.
//   Reset (rst_n low, synchronous): clear all valid bits, the entry count and
//   prune_age; record contents are left as they are, since an invalid slot is
//   never returned.
//   Prune compares each epoch against (current - prune_age) mod 2^16 and
//   also drops entries whose epoch lies after the current epoch.
`timescale 1ns / 1ps
`default_nettype none
module keyed_position_table_with_aging #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [15:0]        in_entry_id,
  input  wire logic [2:0]         in_pos_kind,
  input  wire logic signed [31:0] in_x_mm,
  input  wire logic signed [31:0] in_y_mm,
  input  wire logic [15:0]        in_epoch_value,
  input  wire logic [15:0]        in_pos_err,
  input  wire logic [3:0]         in_start_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_hit,
  output logic [3:0]              out_slot_index,
  output logic [15:0]             out_id,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_x_mm,
  output logic signed [31:0]      out_y_mm,
  output logic [15:0]             out_epoch,
  output logic [15:0]             out_pos_err,
  output logic [4:0]              out_entries_used
);
  kpt_pkg::cmd_t cmd;
  kpt_pkg::sts_t sts;
  logic          need_fill;

  // sequence: load, scan one slot per cycle, optional free-slot fill, output
  kpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .need_fill(need_fill),
    .sts(sts), .cmd(cmd)
  );

  kpt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req_type(in_req_type), .in_entry_id(in_entry_id), .in_pos_kind(in_pos_kind),
    .in_x_mm(in_x_mm), .in_y_mm(in_y_mm), .in_epoch_value(in_epoch_value),
    .in_pos_err(in_pos_err), .in_start_index(in_start_index),
    .cmd(cmd), .sts(sts), .need_fill(need_fill),
    .out_status(out_status), .out_hit(out_hit), .out_slot_index(out_slot_index),
    .out_id(out_id), .out_kind(out_kind), .out_x_mm(out_x_mm), .out_y_mm(out_y_mm),
    .out_epoch(out_epoch), .out_pos_err(out_pos_err),
    .entries_used(out_entries_used)
  );
endmodule
`default_nettype wire

// ===== dv/kpt_checker.sv =====
// Checker for the keyed position table: watches request and result words,
// predicts each result from a private copy of the table and compares.
// Depends on kpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpt_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [15:0]        in_entry_id,
  input  wire logic [2:0]         in_pos_kind,
  input  wire logic signed [31:0] in_x_mm,
  input  wire logic signed [31:0] in_y_mm,
  input  wire logic [15:0]        in_epoch_value,
  input  wire logic [15:0]        in_pos_err,
  input  wire logic [3:0]         in_start_index,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         out_status,
  input  wire logic               out_hit,
  input  wire logic [3:0]         out_slot_index,
  input  wire logic [15:0]        out_id,
  input  wire logic [2:0]         out_kind,
  input  wire logic signed [31:0] out_x_mm,
  input  wire logic signed [31:0] out_y_mm,
  input  wire logic [15:0]        out_epoch,
  input  wire logic [15:0]        out_pos_err,
  input  wire logic [4:0]         out_entries_used,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen
);
  localparam int DEPTH = 16;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] epoch;
    logic [15:0] err;
  } record_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [3:0] slot;
    record_t    rec;
    logic [4:0] used;
  } answer_t;

  logic        live [DEPTH];
  record_t     rec_tab [DEPTH];
  int          used_cnt;
  logic [15:0] age_limit;
  answer_t     answers [$];

  function automatic answer_t make_answer(logic [1:0] st, logic h, int s);
    answer_t a;
    a = '0;
    a.status = st;
    a.hit = h;
    if (s >= 0) begin
      a.slot = s[3:0];
      a.rec = rec_tab[s];
    end
    a.used = used_cnt[4:0];
    return a;
  endfunction

  function automatic answer_t serve_request(logic [2:0] req, record_t r, logic [3:0] start);
    int f;
    logic h;
    logic [15:0] oldest;
    f = -1;
    h = 1'b0;
    case (req)
      kpt_pkg::REQ_ADD: begin
        for (int i = 0; i < DEPTH; i++)
          if (f < 0 && live[i] && rec_tab[i].id == r.id && rec_tab[i].kind == r.kind) begin
            f = i;
            h = 1'b1;
          end
        if (f < 0 && used_cnt < DEPTH)
          for (int i = 0; i < DEPTH; i++)
            if (f < 0 && !live[i]) f = i;
        if (f < 0) return make_answer(kpt_pkg::ST_FULL, 1'b0, -1);
        if (!h) begin
          live[f] = 1'b1;
          used_cnt++;
        end
        rec_tab[f] = r;
        return make_answer(kpt_pkg::ST_OK, h, f);
      end
      kpt_pkg::REQ_LOOKUP, kpt_pkg::REQ_REMOVE: begin
        for (int i = 0; i < DEPTH; i++)
          if (f < 0 && live[i] && rec_tab[i].id == r.id) f = i;
        if (f < 0) return make_answer(kpt_pkg::ST_MISS, 1'b0, -1);
        if (req == kpt_pkg::REQ_REMOVE) begin
          live[f] = 1'b0;
          used_cnt--;
        end
        return make_answer(kpt_pkg::ST_OK, 1'b1, f);
      end
      kpt_pkg::REQ_PRUNE: begin
        if (age_limit != 0) begin
          oldest = r.epoch - age_limit;
          for (int i = 0; i < DEPTH; i++)
            if (live[i] && (rec_tab[i].epoch < oldest || rec_tab[i].epoch > r.epoch)) begin
              live[i] = 1'b0;
              used_cnt--;
            end
        end
        return make_answer(kpt_pkg::ST_OK, 1'b0, -1);
      end
      kpt_pkg::REQ_NEXT: begin
        for (int i = start; i < DEPTH; i++)
          if (f < 0 && live[i]) f = i;
        if (f < 0) return make_answer(kpt_pkg::ST_MISS, 1'b0, -1);
        return make_answer(kpt_pkg::ST_OK, 1'b1, f);
      end
      default: return make_answer(kpt_pkg::ST_MISS, 1'b0, -1);
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t a;
    record_t r;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
      used_cnt = 0;
      age_limit = '0;
      answers.delete();
    end else begin
      if (cfg_we) age_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        results_seen++;
        if (answers.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          a = answers.pop_front();
          check_field("status", a.status, out_status);
          check_field("hit", a.hit, out_hit);
          check_field("slot_index", a.slot, out_slot_index);
          check_field("id", a.rec.id, out_id);
          check_field("kind", a.rec.kind, out_kind);
          check_field("x_mm", a.rec.x, out_x_mm);
          check_field("y_mm", a.rec.y, out_y_mm);
          check_field("epoch", a.rec.epoch, out_epoch);
          check_field("pos_err", a.rec.err, out_pos_err);
          check_field("entries_used", a.used, out_entries_used);
        end
      end
      if (in_valid && in_ready) begin
        r = {in_entry_id, in_pos_kind, in_x_mm, in_y_mm, in_epoch_value, in_pos_err};
        answers.push_back(serve_request(in_req_type, r, in_start_index));
      end
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
  end
endmodule
`default_nettype wire

// ===== dv/keyed_position_table_with_aging_tb.sv =====
// Testbench top for keyed_position_table_with_aging: drives directed and random
// request words, configuration phases and stalls; kpt_checker does the scoring.
// Depends on kpt_pkg, kpt_checker and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module keyed_position_table_with_aging_tb;
  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_req_type;
  logic [15:0]        in_entry_id;
  logic [2:0]         in_pos_kind;
  logic signed [31:0] in_x_mm;
  logic signed [31:0] in_y_mm;
  logic [15:0]        in_epoch_value;
  logic [15:0]        in_pos_err;
  logic [3:0]         in_start_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic               out_hit;
  logic [3:0]         out_slot_index;
  logic [15:0]        out_id;
  logic [2:0]         out_kind;
  logic signed [31:0] out_x_mm;
  logic signed [31:0] out_y_mm;
  logic [15:0]        out_epoch;
  logic [15:0]        out_pos_err;
  logic [4:0]         out_entries_used;

  int fail_count;
  int pending;
  int results_seen;
  int cycle_count;
  int send_idle_pct;   // percent of cycles the sender holds back
  int recv_idle_pct;   // percent of cycles the receiver stalls
  int hold_off;        // cycles left in a long receiver stall
  int words_sent;

  // The limit allows far more than the slow path needs, to cover stalls.
  localparam int CYCLE_LIMIT = 400000;

  keyed_position_table_with_aging uut (.*);

  kpt_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("keyed_position_table_with_aging test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Present one request word, hold it until accepted. Valid stays high after
  // acceptance; the next call or an explicit drop takes it down.
  task automatic send_word(logic [2:0] req, logic [15:0] id, logic [2:0] kind,
                           logic [31:0] x, logic [31:0] y, logic [15:0] ep,
                           logic [15:0] err, logic [3:0] start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_id    <= id;
    in_pos_kind    <= kind;
    in_x_mm        <= x;
    in_y_mm        <= y;
    in_epoch_value <= ep;
    in_pos_err     <= err;
    in_start_index <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Drain all results, give the block time to settle, then write prune_age.
  task automatic set_prune_age(logic [15:0] age);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= age;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request: well-formed table traffic over ids 0 to id_pool, some noise.
  task automatic send_random(int id_pool);
    logic [2:0]  req;
    logic [15:0] id;
    logic [2:0]  kind;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 40)      req = kpt_pkg::REQ_ADD;
    else if (pick < 58) req = kpt_pkg::REQ_LOOKUP;
    else if (pick < 72) req = kpt_pkg::REQ_REMOVE;
    else if (pick < 80) req = kpt_pkg::REQ_PRUNE;
    else if (pick < 95) req = kpt_pkg::REQ_NEXT;
    else                req = 3'($urandom_range(7, 5));
    id   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(id_pool));
    kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                                      3'($urandom_range(kpt_pkg::FIXED));
    send_word(req, id, kind, $urandom, $urandom, 16'($urandom_range(300) + 65400),
              16'($urandom), 4'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = kpt_pkg::REQ_ADD;
    in_entry_id = '0;
    in_pos_kind = kpt_pkg::NONE;
    in_x_mm = '0;
    in_y_mm = '0;
    in_epoch_value = '0;
    in_pos_err = '0;
    in_start_index = '0;
    cycle_count = 0;
    hold_off = 0;
    words_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every request, full table, misses, bad codes.
    send_word(kpt_pkg::REQ_LOOKUP, 16'h0000, kpt_pkg::NONE, '0, '0, '0, '0, '0);
    send_word(kpt_pkg::REQ_NEXT, '0, kpt_pkg::NONE, '0, '0, '0, '0, 4'hF);
    send_word(kpt_pkg::REQ_ADD, 16'hFFFF, kpt_pkg::FIXED, 32'h7FFF_FFFF, 32'h8000_0000,
              16'hFFFF, 16'hFFFF, '0);
    send_word(kpt_pkg::REQ_ADD, 16'h0000, kpt_pkg::NONE, 32'h8000_0000, 32'h7FFF_FFFF,
              '0, '0, '0);
    send_word(kpt_pkg::REQ_ADD, 16'hFFFF, kpt_pkg::FIXED, 32'hFFFF_FFFF, '0, 16'h0005,
              16'h1234, '0);
    send_word(kpt_pkg::REQ_ADD, 16'hFFFF, 3'd7, 32'd1, 32'd2, 16'd3, 16'd4, '0);
    for (int i = 0; i < 13; i++)
      send_word(kpt_pkg::REQ_ADD, 16'(100 + i), kpt_pkg::KNOWN, 32'(i), 32'(-i),
                16'(i), 16'(i), '0);
    send_word(kpt_pkg::REQ_ADD, 16'h4242, kpt_pkg::ESTIMATE, 32'd1, 32'd1, 16'd1, 16'd1,
              '0);
    send_word(kpt_pkg::REQ_NEXT, '0, kpt_pkg::NONE, '0, '0, '0, '0, 4'hF);
    send_word(kpt_pkg::REQ_REMOVE, 16'hFFFF, kpt_pkg::NONE, '0, '0, '0, '0, '0);
    send_word(kpt_pkg::REQ_REMOVE, 16'h7777, kpt_pkg::NONE, '0, '0, '0, '0, '0);
    send_word(3'd5, '0, kpt_pkg::NONE, '0, '0, '0, '0, '0);
    send_word(3'd7, 16'hFFFF, 3'd7, '1, '1, 16'hFFFF, 16'hFFFF, 4'hF);
    send_word(kpt_pkg::REQ_PRUNE, '0, kpt_pkg::NONE, '0, '0, 16'h0003, '0, '0);

    // Prune with aging on, including a current epoch below stored ones.
    set_prune_age(16'h0001);
    send_word(kpt_pkg::REQ_PRUNE, '0, kpt_pkg::NONE, '0, '0, 16'h0008, '0, '0);
    send_word(kpt_pkg::REQ_NEXT, '0, kpt_pkg::NONE, '0, '0, '0, '0, '0);
    set_prune_age(16'hFFFF);
    send_word(kpt_pkg::REQ_PRUNE, '0, kpt_pkg::NONE, '0, '0, 16'h0000, '0, '0);

    // Random phases with the three idling patterns and several age settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 19; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: set_prune_age(16'd0);
        1: set_prune_age(16'd100);
        2: set_prune_age(16'd30);
        3: set_prune_age(16'hFFFF);
        4: set_prune_age(16'd1);
        default: set_prune_age(16'($urandom_range(200, 2)));
      endcase
      for (int n = 0; n < 290; n++) begin
        // Long receiver hold-off while the sender keeps presenting words.
        if (phase == 2 && n == 50) hold_off = 400;
        send_random(phase < 3 ? 24 : 65535 >> ($urandom_range(1) * 12));
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d request words, checked %0d results over six idling phases",
             words_sent, results_seen);
    $display("prune_age swept from 0 to 0xFFFF; table filled, drained and aged");
    if (fail_count == 0) begin
      $display("keyed_position_table_with_aging test passed");
    end else begin
      $display("keyed_position_table_with_aging test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
